FILE: rtl/preamble_frame_receiver_addr_filter_defines.svh
// Assertion macros for the preamble frame receiver checker.
// Depends on signals named clock and reset in the using scope.
`ifndef PREAMBLE_FRAME_RECEIVER_ADDR_FILTER_DEFINES_SVH
`define PREAMBLE_FRAME_RECEIVER_ADDR_FILTER_DEFINES_SVH

// checked only outside reset
`define PFRAF_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define PFRAF_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/pfraf_pkg.sv
// Shared types, codes and constants of the preamble frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfraf_pkg;

   localparam int MAX_FRAME_LEN_DEF = 32;
   localparam int PREAMBLE_LEN_DEF  = 5;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 6;
   localparam int PRE_W   = 3;
   localparam int IDX_W   = 6;
   localparam int TICK_W  = 16;
   localparam int PLEN_W  = 5;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 16;
   localparam int Q_CNT_W = 2;

   localparam logic [BYTE_W-1:0] SYNC_CHAR = 8'h23;
   localparam logic [BYTE_W-1:0] BROADCAST = 8'hFF;
   localparam logic [BYTE_W-1:0] MIN_LEN   = 8'd4;
   localparam int                HDR_BYTES = 2;
   localparam int                Q_DEPTH   = 2;

   localparam logic [BYTE_W-1:0] OWN_ADDR_RST = 8'd0;
   localparam logic [LEN_W-1:0]  MIN_LEN_RST  = 6'd4;
   localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 6'd32;
   localparam logic [TICK_W-1:0] TIMEOUT_RST  = 16'd100;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_OWN_ADDR = 2'd0,
      CSR_MIN_LEN  = 2'd1,
      CSR_MAX_LEN  = 2'd2,
      CSR_TIMEOUT  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_LEN_ERR  = 3'd1,
      STAT_TIMEOUT  = 3'd2,
      STAT_CHK_ERR  = 3'd3,
      STAT_ADDR_MISS = 3'd4
   } status_type;

   typedef struct packed {
      status_type         status;
      logic               data_valid;
      logic [BYTE_W-1:0]  data_byte;
      logic [BYTE_W-1:0]  source_address;
      logic [PLEN_W-1:0]  payload_length;
      logic               last;
   } result_type;

   typedef struct packed {
      logic               push;
      logic               start;
      result_type         res;
   } rx_cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  own_address;
      logic [LEN_W-1:0]   min_length;
      logic [LEN_W-1:0]   max_length;
      logic [TICK_W-1:0]  timeout_ticks;
   } cfg_type;

   function automatic int f_len_ceil(input int max_frame_len);
      return (max_frame_len > 32) ? 32 : max_frame_len;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/preamble_frame_receiver_addr_filter.sv
// A status result is pushed into the output queue by the item that causes it; a good
// frame's first payload byte passes the store read register, then the queue. One item
// per cycle while the queue is not full; after a good frame req_tready stays low while
// the frame store read port streams one payload byte a cycle when the queue has room.
// Reset: synchronous, clears control state and CSR registers; data registers and frame store not cleared.
`timescale 1ns / 1ps
`default_nettype none

module preamble_frame_receiver_addr_filter import pfraf_pkg::*; #(
   parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
   parameter int PREAMBLE_LEN  = PREAMBLE_LEN_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] rx_byte
   input  wire logic               req_tuser,   // [0] opcode
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic      [23:0]        rsp_tdata,   // [7:0] data_byte, [15:8] source_address,
                                                // [20:16] payload_length, [23:21] zero
   output logic      [3:0]         rsp_tuser,   // [2:0] status, [3] data_valid
   output logic                    rsp_tlast,
   input  wire logic               csr_wen,
   input  wire logic [CSR_A_W-1:0] csr_addr,
   input  wire logic [CSR_D_W-1:0] csr_wdata
);

   localparam int LEN_CEIL = f_len_ceil(MAX_FRAME_LEN);
   localparam int AW       = $clog2(LEN_CEIL);

   cfg_type           cfg_ff, cfg_in;
   rx_cmd_type        cmd;
   result_type        item;
   logic              accept, busy;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            CSR_OWN_ADDR: cfg_in.own_address   = csr_wdata[BYTE_W-1:0];
            CSR_MIN_LEN:  cfg_in.min_length    = csr_wdata[LEN_W-1:0];
            CSR_MAX_LEN:  cfg_in.max_length    = csr_wdata[LEN_W-1:0];
            CSR_TIMEOUT:  cfg_in.timeout_ticks = csr_wdata[TICK_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address   <= OWN_ADDR_RST;
         cfg_ff.min_length    <= MIN_LEN_RST;
         cfg_ff.max_length    <= MAX_LEN_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !busy;
   assign accept     = req_tvalid && !busy;

   pfraf_rx #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN),
      .PREAMBLE_LEN  (PREAMBLE_LEN)
   ) u_rx (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_opcode (req_tuser),
      .in_byte   (req_tdata),
      .cfg       (cfg_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .cmd       (cmd)
   );

   pfraf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LEN_CEIL)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfraf_out #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_item  (item),
      .busy      (busy)
   );

   assign rsp_tdata = {3'b000, item.payload_length, item.source_address, item.data_byte};
   assign rsp_tuser = {item.data_valid, item.status};
   assign rsp_tlast = item.last;

endmodule

`default_nettype wire

FILE: rtl/pfraf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfraf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/pfraf_rx.sv
// Receive parser: preamble hunt, length check, frame store writes, checksum,
// address filter and timeout. Depends on pfraf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfraf_rx import pfraf_pkg::*; #(
   parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
   parameter int PREAMBLE_LEN  = PREAMBLE_LEN_DEF,
   localparam int LEN_CEIL     = f_len_ceil(MAX_FRAME_LEN),
   localparam int AW           = $clog2(LEN_CEIL)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_accept,
   input  wire logic              in_opcode,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire cfg_type           cfg,
   output logic                   wr_en,
   output logic      [AW-1:0]     wr_addr,
   output logic      [BYTE_W-1:0] wr_data,
   output rx_cmd_type             cmd
);

   typedef enum logic [1:0] {
      MODE_HUNT = 2'b01,
      MODE_READ = 2'b10
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [PRE_W-1:0]  pre_ff, pre_in, pre_nx;
   logic [IDX_W-1:0]  idx_ff, idx_in, idx_nx, idx_m1;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [TICK_W-1:0] tick_ff, tick_in, tick_nx;
   logic [BYTE_W-1:0] src_ff, src_in;
   logic [BYTE_W-1:0] dst_ff, dst_in;
   logic [LEN_W-1:0]  plen_full;
   logic              len_ok;
   logic              go_hunt;

   always_comb begin
      pre_nx    = pre_ff + PRE_W'(1);
      idx_nx    = idx_ff + IDX_W'(1);
      idx_m1    = idx_ff - IDX_W'(1);
      tick_nx   = tick_ff + TICK_W'(1);
      plen_full = len_ff - LEN_W'(MIN_LEN);
      len_ok    = (in_byte >= {2'b00, cfg.min_length}) &&
                  (in_byte <= {2'b00, cfg.max_length}) &&
                  (in_byte >= MIN_LEN) && (in_byte <= BYTE_W'(LEN_CEIL));

      mode_in = mode_ff;
      pre_in  = pre_ff;
      idx_in  = idx_ff;
      len_in  = len_ff;
      sum_in  = sum_ff;
      tick_in = tick_ff;
      src_in  = src_ff;
      dst_in  = dst_ff;
      go_hunt = 1'b0;
      wr_en   = 1'b0;
      wr_addr = idx_m1[AW-1:0];
      wr_data = in_byte;
      cmd     = '0;
      cmd.res.last = 1'b1;

      if (in_accept) begin
         if (in_opcode == OP_TICK) begin
            if (mode_ff == MODE_READ) begin
               tick_in = tick_nx;
               if (tick_nx >= cfg.timeout_ticks) begin
                  go_hunt = 1'b1;
                  cmd.push = 1'b1;
                  cmd.res.status = STAT_TIMEOUT;
               end
            end
         end else if (mode_ff == MODE_HUNT) begin
            if (in_byte == SYNC_CHAR) begin
               pre_in = pre_nx;
               if (pre_nx >= PRE_W'(PREAMBLE_LEN)) begin
                  mode_in = MODE_READ;
                  pre_in  = '0;
                  idx_in  = '0;
                  tick_in = '0;
               end
            end else begin
               pre_in = '0;
            end
         end else if (idx_ff == '0) begin
            if (!len_ok) begin
               go_hunt = 1'b1;
               cmd.push = 1'b1;
               cmd.res.status = STAT_LEN_ERR;
            end else begin
               len_in = in_byte[LEN_W-1:0];
               sum_in = in_byte;
               idx_in = IDX_W'(1);
            end
         end else begin
            wr_en  = 1'b1;
            idx_in = idx_nx;
            if (idx_ff == IDX_W'(1)) begin
               src_in = in_byte;
            end
            if (idx_ff == IDX_W'(2)) begin
               dst_in = in_byte;
            end
            if (idx_nx >= IDX_W'(len_ff)) begin
               go_hunt = 1'b1;
               if (in_byte != sum_ff) begin
                  cmd.push = 1'b1;
                  cmd.res.status = STAT_CHK_ERR;
               end else begin
                  cmd.res.source_address = src_ff;
                  cmd.res.payload_length = plen_full[PLEN_W-1:0];
                  if (dst_ff != cfg.own_address && dst_ff != BROADCAST) begin
                     cmd.push = 1'b1;
                     cmd.res.status = STAT_ADDR_MISS;
                  end else if (plen_full == '0) begin
                     cmd.push = 1'b1;
                     cmd.res.status = STAT_OK;
                  end else begin
                     cmd.start = 1'b1;
                  end
               end
            end else begin
               sum_in = sum_ff + in_byte;
            end
         end
      end

      if (go_hunt) begin
         mode_in = MODE_HUNT;
         pre_in  = '0;
         idx_in  = '0;
         tick_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HUNT;
         pre_ff  <= '0;
         idx_ff  <= '0;
         tick_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pre_ff  <= pre_in;
         idx_ff  <= idx_in;
         tick_ff <= tick_in;
      end
      len_ff <= len_in;
      sum_ff <= sum_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
   end

endmodule

`default_nettype wire

FILE: rtl/pfraf_out.sv
// Result side: payload reader walking the frame store and a two-entry
// output queue. Depends on pfraf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfraf_out import pfraf_pkg::*; #(
   parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
   localparam int LEN_CEIL     = f_len_ceil(MAX_FRAME_LEN),
   localparam int AW           = $clog2(LEN_CEIL)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rx_cmd_type        cmd,
   output logic                   rd_en,
   output logic      [AW-1:0]     rd_addr,
   input  wire logic [BYTE_W-1:0] rd_data,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output result_type             rsp_item,
   output logic                   busy
);

   logic               active_ff, active_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [PLEN_W-1:0]  rem_ff, rem_in;
   logic [BYTE_W-1:0]  src_ff, src_in;
   logic [PLEN_W-1:0]  plen_ff, plen_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in, cnt_left;
   result_type         head_ff, head_in, tail_ff, tail_in;
   result_type         push_item;
   logic               push, pop, space;

   always_comb begin
      pop      = (cnt_ff != '0) && rsp_ready;
      cnt_left = cnt_ff - Q_CNT_W'(pop);
      space    = (cnt_left != Q_CNT_W'(Q_DEPTH));

      active_in = active_ff;
      addr_in   = addr_ff;
      rem_in    = rem_ff;
      src_in    = src_ff;
      plen_in   = plen_ff;
      rd_en     = 1'b0;
      rd_addr   = addr_ff + AW'(1);
      push      = cmd.push;
      push_item = cmd.res;

      if (cmd.start) begin
         active_in = 1'b1;
         addr_in   = AW'(HDR_BYTES);
         rem_in    = cmd.res.payload_length;
         src_in    = cmd.res.source_address;
         plen_in   = cmd.res.payload_length;
         rd_en     = 1'b1;
         rd_addr   = AW'(HDR_BYTES);
      end else if (active_ff && space) begin
         push                     = 1'b1;
         push_item.status         = STAT_OK;
         push_item.data_valid     = 1'b1;
         push_item.data_byte      = rd_data;
         push_item.source_address = src_ff;
         push_item.payload_length = plen_ff;
         push_item.last           = (rem_ff == PLEN_W'(1));
         if (rem_ff == PLEN_W'(1)) begin
            active_in = 1'b0;
         end else begin
            rd_en   = 1'b1;
            addr_in = addr_ff + AW'(1);
            rem_in  = rem_ff - PLEN_W'(1);
         end
      end

      head_in = head_ff;
      tail_in = tail_ff;
      if (pop) begin
         head_in = tail_ff;
      end
      if (push) begin
         if (cnt_left == '0) begin
            head_in = push_item;
         end else begin
            tail_in = push_item;
         end
      end
      cnt_in = cnt_left + Q_CNT_W'(push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      plen_ff <= plen_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_item  = head_ff;
   assign busy      = active_ff || (cnt_ff == Q_CNT_W'(Q_DEPTH));

endmodule

`default_nettype wire

FILE: rtl/pfraf_checker.sv
// Port-level checks of the preamble frame receiver, bound to the top level.
// Depends on pfraf_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "preamble_frame_receiver_addr_filter_defines.svh"

module pfraf_checker import pfraf_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tready,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [23:0]        rsp_tdata,
   input wire logic [3:0]         rsp_tuser,
   input wire logic               rsp_tlast
);

   `PFRAF_CHECK_ALWAYS(a_empty_after_reset,
      $past(reset) && !reset |-> !rsp_tvalid,
      "rsp valid after reset")

   `PFRAF_CHECK(a_stall_hold,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled rsp item changed")

   `PFRAF_CHECK(a_burst_blocks_input,
      rsp_tvalid && rsp_tuser[3] && !rsp_tlast |-> !req_tready,
      "input taken during payload burst")

   `PFRAF_CHECK(a_burst_continues,
      rsp_tvalid && rsp_tready && rsp_tuser[3] && !rsp_tlast |=> rsp_tvalid &&
      rsp_tuser[3] && rsp_tdata[15:8] == $past(rsp_tdata[15:8]),
      "payload burst broken")

   `PFRAF_CHECK(a_status_single,
      rsp_tvalid && (!rsp_tuser[3] || rsp_tuser[2:0] != STAT_OK) |->
      rsp_tlast && !rsp_tuser[3],
      "status item not single")

endmodule

bind preamble_frame_receiver_addr_filter pfraf_checker u_pfraf_checker (.*);

`default_nettype wire

FILE: tb/sv/preamble_frame_receiver_addr_filter_test.sv
// Self-checking bench for the preamble frame receiver with address filter.
// Drives byte and tick items, predicts every result in a local frame model, checks rsp.
// Depends on pfraf_pkg and preamble_frame_receiver_addr_filter.
`timescale 1ns / 1ps

module preamble_frame_receiver_addr_filter_test;
   import pfraf_pkg::*;

   localparam int LEN_CEIL     = (MAX_FRAME_LEN_DEF > 32) ? 32 : MAX_FRAME_LEN_DEF;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int REPORT_MAX   = 10;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = 8'h00;
   logic               req_tuser  = OP_BYTE;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [23:0]        rsp_tdata;
   logic [3:0]         rsp_tuser;
   logic               rsp_tlast;
   logic               csr_wen    = 1'b0;
   logic [CSR_A_W-1:0] csr_addr   = CSR_OWN_ADDR;
   logic [CSR_D_W-1:0] csr_wdata  = '0;

   preamble_frame_receiver_addr_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // frame model state
   cfg_type            cfg;
   logic               armed;
   logic [2:0]         sync_run;
   logic [5:0]         rx_index;
   logic [5:0]         rx_length;
   logic [7:0]         rx_sum;
   logic [15:0]        tick_run;
   logic [7:0]         rx_store [0:63];

   result_type         pending_results [$];
   int                 fail_count      = 0;
   int                 items_sent      = 0;
   int                 send_idle_pct   = 0;
   int                 stall_pct       = 0;
   int                 holds_requested = 0;
   int                 holds_served    = 0;
   int                 hold_left       = 0;

   task automatic go_hunting();
      armed    = 1'b0;
      sync_run = '0;
      rx_index = '0;
      tick_run = '0;
   endtask

   task automatic push_result(input status_type st, input logic dv, input logic [7:0] db,
                              input logic [7:0] src, input logic [4:0] plen, input logic lst);
      result_type r;
      r.status         = st;
      r.data_valid     = dv;
      r.data_byte      = db;
      r.source_address = src;
      r.payload_length = plen;
      r.last           = lst;
      pending_results.push_back(r);
   endtask

   task automatic close_frame();
      logic [7:0] src;
      logic [7:0] dst;
      logic [4:0] plen;
      int         i;
      go_hunting();
      if (rx_store[rx_length - 6'd2] != rx_sum) begin
         push_result(STAT_CHK_ERR, 1'b0, 8'h00, 8'h00, 5'd0, 1'b1);
      end else begin
         src  = rx_store[0];
         dst  = rx_store[1];
         plen = 5'(rx_length - 6'd4);
         if (dst != cfg.own_address && dst != BROADCAST) begin
            push_result(STAT_ADDR_MISS, 1'b0, 8'h00, src, plen, 1'b1);
         end else if (plen == 5'd0) begin
            push_result(STAT_OK, 1'b0, 8'h00, src, 5'd0, 1'b1);
         end else begin
            for (i = 0; i < plen; i++)
               push_result(STAT_OK, 1'b1, rx_store[6'(2 + i)], src, plen, (i + 1 == plen));
         end
      end
   endtask

   // advance the frame model by one accepted item
   task automatic model_item(input logic op, input logic [7:0] b);
      if (op == OP_TICK) begin
         if (armed) begin
            tick_run = tick_run + 16'd1;
            if (tick_run >= cfg.timeout_ticks) begin
               go_hunting();
               push_result(STAT_TIMEOUT, 1'b0, 8'h00, 8'h00, 5'd0, 1'b1);
            end
         end
      end else if (!armed) begin
         if (b == SYNC_CHAR) begin
            sync_run = sync_run + 3'd1;
            if (sync_run >= PREAMBLE_LEN_DEF) begin
               armed    = 1'b1;
               sync_run = '0;
               rx_index = '0;
               tick_run = '0;
            end
         end else begin
            sync_run = '0;
         end
      end else if (rx_index == 6'd0) begin
         if (b < cfg.min_length || b > cfg.max_length || b < MIN_LEN || b > LEN_CEIL) begin
            go_hunting();
            push_result(STAT_LEN_ERR, 1'b0, 8'h00, 8'h00, 5'd0, 1'b1);
         end else begin
            rx_length = b[5:0];
            rx_sum    = b;
            rx_index  = 6'd1;
         end
      end else begin
         rx_store[rx_index - 6'd1] = b;
         rx_index = rx_index + 6'd1;
         if (rx_index >= rx_length)
            close_frame();
         else
            rx_sum = rx_sum + b;
      end
   endtask

   task automatic model_reset();
      cfg.own_address   = OWN_ADDR_RST;
      cfg.min_length    = MIN_LEN_RST;
      cfg.max_length    = MAX_LEN_RST;
      cfg.timeout_ticks = TIMEOUT_RST;
      go_hunting();
      rx_length = '0;
      rx_sum    = '0;
   endtask

   // one item on req; the model follows at the accepting edge
   task automatic send_item(input logic op, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model_item(op, b);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_D_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_OWN_ADDR: cfg.own_address   = val[7:0];
         CSR_MIN_LEN:  cfg.min_length    = val[5:0];
         CSR_MAX_LEN:  cfg.max_length    = val[5:0];
         CSR_TIMEOUT:  cfg.timeout_ticks = val[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] own, input logic [5:0] lo, input logic [5:0] hi,
                            input logic [15:0] tmo);
      wait_idle();
      write_reg(CSR_OWN_ADDR, {8'h00, own});
      write_reg(CSR_MIN_LEN, {10'h000, lo});
      write_reg(CSR_MAX_LEN, {10'h000, hi});
      write_reg(CSR_TIMEOUT, tmo);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_preamble();
      repeat (PREAMBLE_LEN_DEF) send_item(OP_BYTE, SYNC_CHAR);
   endtask

   // preamble, length, then the body while the model says the frame is still open
   task automatic send_frame(input logic [7:0] len, input logic [7:0] src, input logic [7:0] dst,
                             input bit bad_sum, input int tick_pct);
      logic [7:0] body [$];
      logic [7:0] sum;
      int         i;
      body = {src, dst};
      for (i = 4; i < len; i++) body.push_back(8'($urandom_range(255)));
      sum = len;
      foreach (body[k]) sum = sum + body[k];
      if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
      body.push_back(sum);
      send_preamble();
      send_item(OP_BYTE, len);
      for (i = 0; i < body.size() && armed; i++) begin
         if ($urandom_range(99) < tick_pct) send_item(OP_TICK, 8'($urandom_range(255)));
         if (armed) send_item(OP_BYTE, body[i]);
      end
   endtask

   task automatic send_noise(input int count);
      int i;
      int r;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(9);
         if (r < 3)
            send_item(OP_TICK, 8'($urandom_range(255)));
         else if (r < 6)
            send_item(OP_BYTE, SYNC_CHAR);
         else
            send_item(OP_BYTE, 8'($urandom_range(255)));
      end
      if (!armed && sync_run != 0) send_item(OP_BYTE, 8'h00);
   endtask

   // preamble and usually a random length, cut short, then ticks until the timeout if it is at most 64
   task automatic send_broken();
      int n;
      int i;
      send_preamble();
      if ($urandom_range(3) != 0) send_item(OP_BYTE, 8'($urandom_range(255)));
      n = $urandom_range(6);
      for (i = 0; i < n && armed; i++) send_item(OP_BYTE, 8'($urandom_range(255)));
      if (cfg.timeout_ticks <= 16'd64)
         while (armed) send_item(OP_TICK, 8'($urandom_range(255)));
   endtask

   function automatic logic [7:0] pick_length();
      int lo;
      int hi;
      lo = cfg.min_length;
      hi = cfg.max_length;
      if (lo > hi || $urandom_range(19) == 0) return 8'($urandom_range(255));
      if ($urandom_range(3) == 0) return 8'(hi);
      return 8'($urandom_range(lo, (hi < lo + 8) ? hi : lo + 8));
   endfunction

   function automatic logic [7:0] pick_dest();
      int r;
      r = $urandom_range(99);
      if (r < 40) return cfg.own_address;
      if (r < 65) return BROADCAST;
      return 8'($urandom_range(255));
   endfunction

   task automatic random_traffic(input int n, input int tick_pct);
      int start;
      int r;
      start = items_sent;
      while (items_sent - start < n) begin
         r = $urandom_range(99);
         if (r < 72)
            send_frame(pick_length(), 8'($urandom_range(255)), pick_dest(),
                       $urandom_range(99) < 12, tick_pct);
         else if (r < 84)
            send_noise($urandom_range(1, 6));
         else
            send_broken();
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_hunting_noise();
      send_item(OP_TICK, 8'hFF);
      send_item(OP_TICK, 8'h00);
      repeat (4) send_item(OP_BYTE, SYNC_CHAR);
      send_item(OP_BYTE, 8'h41);
      send_item(OP_TICK, 8'h5A);
   endtask

   task automatic test_length_errors();
      send_preamble();
      send_item(OP_BYTE, 8'h03);
      send_preamble();
      send_item(OP_BYTE, SYNC_CHAR);
      send_preamble();
      send_item(OP_BYTE, 8'hFF);
   endtask

   task automatic test_frame_outcomes();
      send_frame(8'd4, 8'h00, 8'h00, 1'b0, 0);
      send_frame(8'd5, 8'hFF, 8'hFF, 1'b1, 0);
      send_frame(8'd6, 8'hA5, 8'h7E, 1'b0, 0);
      send_frame(8'd8, 8'hFF, BROADCAST, 1'b0, 0);
   endtask

   task automatic test_timeout();
      configure(8'h00, 6'd4, 6'd32, 16'd2);
      send_preamble();
      send_item(OP_TICK, 8'h00);
      send_item(OP_TICK, 8'hFF);
      send_preamble();
      send_item(OP_BYTE, 8'd10);
      send_item(OP_BYTE, 8'h12);
      send_item(OP_TICK, 8'h00);
      send_item(OP_BYTE, 8'h34);
      send_item(OP_TICK, 8'h00);
   endtask

   task automatic test_no_idle();
      configure(8'h00, 6'd4, 6'd32, 16'd100);
      send_idle_pct = 0;
      stall_pct     = 0;
      random_traffic(40, 3);
   endtask

   task automatic test_sender_idle();
      configure(8'hFF, 6'd32, 6'd32, 16'hFFFF);
      send_idle_pct = 64;
      stall_pct     = 0;
      random_traffic(25, 5);
   endtask

   task automatic test_receiver_stall();
      configure(8'($urandom_range(255)), 6'd4, 6'd4, 16'd1);
      send_idle_pct = 0;
      stall_pct     = 64;
      random_traffic(25, 4);
   endtask

   task automatic test_both_idle();
      int lo;
      lo = $urandom_range(4, 16);
      configure(8'($urandom_range(255)), 6'(lo), 6'($urandom_range(lo, 32)),
                16'($urandom_range(2, 40)));
      send_idle_pct = 24;
      stall_pct     = 24;
      random_traffic(30, 8);
   endtask

   task automatic test_inverted_bounds();
      configure(8'h5A, 6'd30, 6'd6, 16'd100);
      send_idle_pct = 0;
      stall_pct     = 0;
      random_traffic(10, 0);
   endtask

   task automatic test_backpressure();
      configure(8'h11, 6'd4, 6'd32, 16'd1000);
      send_idle_pct = 0;
      stall_pct     = 0;
      holds_requested++;
      repeat (2) send_frame(8'd24, 8'($urandom_range(255)), BROADCAST, 1'b0, 0);
      send_frame(8'd32, 8'($urandom_range(255)), 8'h11, 1'b0, 0);
   endtask

   // ---------------- receiver and checker ----------------
   always @(posedge clock) begin
      if (hold_left == 0 && holds_served != holds_requested) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status         = status_type'(rsp_tuser[2:0]);
         got.data_valid     = rsp_tuser[3];
         got.data_byte      = rsp_tdata[7:0];
         got.source_address = rsp_tdata[15:8];
         got.payload_length = rsp_tdata[20:16];
         got.last           = rsp_tlast;
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("unexpected item: st=%0d dv=%b db=%h src=%h len=%0d last=%b",
                        got.status, got.data_valid, got.data_byte, got.source_address,
                        got.payload_length, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.data_valid !== want.data_valid ||
                got.data_byte !== want.data_byte ||
                got.source_address !== want.source_address ||
                got.payload_length !== want.payload_length || got.last !== want.last) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display({"mismatch: exp st=%0d dv=%b db=%h src=%h len=%0d last=%b",
                            " | got st=%0d dv=%b db=%h src=%h len=%0d last=%b"},
                           want.status, want.data_valid, want.data_byte,
                           want.source_address, want.payload_length, want.last,
                           got.status, got.data_valid, got.data_byte,
                           got.source_address, got.payload_length, got.last);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      model_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_hunting_noise();
      test_length_errors();
      test_frame_outcomes();
      test_timeout();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_inverted_bounds();
      test_backpressure();
      wait_idle();
      if (fail_count == 0 && pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: preamble_frame_receiver_addr_filter.f
+incdir+rtl
rtl/pfraf_pkg.sv
rtl/pfraf_ram.sv
rtl/pfraf_rx.sv
rtl/pfraf_out.sv
rtl/preamble_frame_receiver_addr_filter.sv
rtl/pfraf_checker.sv
tb/sv/preamble_frame_receiver_addr_filter_test.sv
